// ----- hdl/bpm_pkg.sv -----
// shared types, constants and helpers for the transmit buffer pool manager
package bpm_pkg;

  localparam int NUM_BUFFERS  = 3;
  localparam int BUFFER_BYTES = 128;

  localparam int IDX_W    = $clog2(NUM_BUFFERS);
  localparam int LABEL_W  = 4;
  localparam int SIZE_W   = 8;
  localparam int FILL_W   = 8;
  localparam int OFFSET_W = 7;
  localparam int LENGTH_W = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [LABEL_W-1:0] LABEL_FREE = LABEL_W'(0);
  localparam logic [LABEL_W-1:0] LABEL_DMA  = LABEL_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_LABEL_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_HIGH = CFG_IDX_W'(1);

  localparam logic [LABEL_W-1:0] LABEL_LOW_RST  = LABEL_W'(2);
  localparam logic [LABEL_W-1:0] LABEL_HIGH_RST = LABEL_W'(15);

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_COMMIT  = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_SERVICE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BUSY      = 3'd1,
    ST_NO_DATA   = 3'd2,
    ST_ALL_BUSY  = 3'd3,
    ST_TOO_BIG   = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_NOT_EXIST = 3'd6
  } status_t;

  // outcome of evaluating one buffer entry
  typedef struct packed {
    logic                done;
    logic                grant;
    logic                wr_owner;
    logic [LABEL_W-1:0]  owner;
    logic                wr_fill;
    logic [FILL_W-1:0]   fill;
    status_t             status;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic                start;
  } step_res_t;

  // status when the walk runs off the end of the pool
  function automatic status_t end_status(input action_t act);
    status_t st;
    case (act)
      ACT_ACQUIRE: st = ST_ALL_BUSY;
      ACT_COMMIT:  st = ST_NOT_EXIST;
      ACT_RELEASE: st = ST_OK;
      ACT_SERVICE: st = ST_NO_DATA;
      default:     st = ST_OK;
    endcase
    return st;
  endfunction

endpackage

// ----- hdl/tx_buffer_pool_manager.sv -----
// top level of the transmit buffer pool manager: sequencer, pool state and result register
// result: for a request rejected up front (busy, bad label, too big) the result register is
//   loaded at acceptance, else after a walk of k (1..NUM_BUFFERS) buffers, one per cycle
// throughput: one transaction at a time; in_stall stays high from acceptance until the result
//   transaction is taken
// reset: synchronous active-low rst_n frees every buffer, zeroes fill counts, window 2..15
module tx_buffer_pool_manager (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_action,
  input  logic [bpm_pkg::LABEL_W-1:0]        in_user,
  input  logic [bpm_pkg::SIZE_W-1:0]         in_size,
  input  logic                               in_channel_busy,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bpm_pkg::STATUS_W-1:0]       out_status,
  output logic [bpm_pkg::IDX_W-1:0]          out_buffer_index,
  output logic [bpm_pkg::OFFSET_W-1:0]       out_write_offset,
  output logic [bpm_pkg::LENGTH_W-1:0]       out_transfer_length,
  output logic                               out_start_transfer,
  // register write port
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpm_pkg::LABEL_W-1:0]        cfg_data
);
  import bpm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  // request held for the walk
  action_t             act_r;
  logic [LABEL_W-1:0]  user_r;
  logic [SIZE_W-1:0]   size_r;

  // pool state
  logic [LABEL_W-1:0]  owner_r [NUM_BUFFERS];
  logic [FILL_W-1:0]   fill_r  [NUM_BUFFERS];

  // label window registers
  logic [LABEL_W-1:0]  label_low_r, label_high_r;

  // result register
  status_t             status_r;
  logic [IDX_W-1:0]    index_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [LENGTH_W-1:0] length_r;
  logic                start_r;

  action_t             in_act;
  logic                in_xact, out_xact;
  logic                label_ok;
  logic                reject;
  status_t             reject_status;
  logic                last;
  step_res_t           step;

  assign in_act   = action_t'(in_action);
  assign in_stall = (state_r != S_IDLE);
  assign in_xact  = in_valid && !in_stall;
  assign out_valid = (state_r == S_DONE);
  assign out_xact = out_valid && !out_stall;
  assign cfg_ready = 1'b1;
  assign last     = (idx_r == LAST_IDX);

  assign out_status          = status_r;
  assign out_buffer_index    = index_r;
  assign out_write_offset    = offset_r;
  assign out_transfer_length = length_r;
  assign out_start_transfer  = start_r;

  // reserved labels and anything outside the window are unknown owners
  assign label_ok = (in_user != LABEL_FREE) && (in_user != LABEL_DMA) &&
                    (in_user >= label_low_r) && (in_user <= label_high_r);

  // checks settled at acceptance, before any walk
  always_comb begin
    reject        = 1'b0;
    reject_status = ST_OK;
    if (in_act == ACT_SERVICE) begin
      if (in_channel_busy) begin
        reject        = 1'b1;
        reject_status = ST_BUSY;
      end
    end else if (!label_ok) begin
      reject        = 1'b1;
      reject_status = ST_NOT_EXIST;
    end else if (in_act == ACT_COMMIT &&
                 {1'b0, in_size} > (SIZE_W+1)'(BUFFER_BYTES)) begin
      reject        = 1'b1;
      reject_status = ST_TOO_BIG;
    end
  end

  // one buffer entry per cycle through the shared unit
  bpm_step_unit u_step (
    .act   (act_r),
    .user  (user_r),
    .size  (size_r),
    .owner (owner_r[idx_r]),
    .fill  (fill_r[idx_r]),
    .res   (step)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_xact) begin
          state_nxt = reject ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        if (step.done || last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_xact) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_xact) begin
      act_r  <= in_act;
      user_r <= in_user;
      size_r <= in_size;
    end
  end

  // label window registers, writes to unknown indices are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_low_r  <= LABEL_LOW_RST;
      label_high_r <= LABEL_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LABEL_LOW) begin
        label_low_r <= cfg_data;
      end else if (cfg_index == REG_LABEL_HIGH) begin
        label_high_r <= cfg_data;
      end
    end
  end

  // pool state, written only by the walk at the current entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        owner_r[i] <= LABEL_FREE;
        fill_r[i]  <= '0;
      end
    end else if (state_r == S_WALK) begin
      if (step.wr_owner) begin
        owner_r[idx_r] <= step.owner;
      end
      if (step.wr_fill) begin
        fill_r[idx_r] <= step.fill;
      end
    end
  end

  // result register, loaded once per transaction and held until taken
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_xact && reject) begin
      status_r <= reject_status;
      index_r  <= '0;
      offset_r <= '0;
      length_r <= '0;
      start_r  <= 1'b0;
    end else if (state_r == S_WALK) begin
      if (step.done) begin
        status_r <= step.status;
        index_r  <= step.grant ? idx_r : '0;
        offset_r <= step.offset;
        length_r <= step.length;
        start_r  <= step.start;
      end else if (last) begin
        status_r <= end_status(act_r);
        index_r  <= '0;
        offset_r <= '0;
        length_r <= '0;
        start_r  <= 1'b0;
      end
    end
  end

  // walk index stays inside the pool
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (idx_r <= LAST_IDX))
    else $error("walk index beyond pool");

  // a hand-over always reports ok with a non-empty length
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_start_transfer) |->
      (out_status == ST_OK && out_transfer_length != '0))
    else $error("hand-over without ok status or data");

  // an accepted request always leaves idle on the next edge
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xact |=> (state_r != S_IDLE))
    else $error("accepted request lost");

  // a taken result returns the sequencer to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_xact |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle");

  // fill counts never reach the buffer size
  for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_fill_chk
    assert property (@(posedge clk) disable iff (!rst_n)
      fill_r[g] < FILL_W'(BUFFER_BYTES))
      else $error("fill count reached buffer size");
  end

endmodule

// ----- hdl/bpm_step_unit.sv -----
// shared compare and add unit that evaluates one buffer entry per cycle
module bpm_step_unit (
  input  bpm_pkg::action_t                  act,
  input  logic [bpm_pkg::LABEL_W-1:0]       user,
  input  logic [bpm_pkg::SIZE_W-1:0]        size,
  input  logic [bpm_pkg::LABEL_W-1:0]       owner,
  input  logic [bpm_pkg::FILL_W-1:0]        fill,
  output bpm_pkg::step_res_t                res
);
  import bpm_pkg::*;

  logic [FILL_W:0] sum;
  logic            fits;

  // one adder and one compare serve both acquire and commit
  assign sum  = {1'b0, fill} + {1'b0, size};
  assign fits = sum < (FILL_W+1)'(BUFFER_BYTES);

  always_comb begin
    res          = '0;
    res.status   = ST_OK;
    res.owner    = owner;
    res.fill     = fill;
    case (act)
      ACT_ACQUIRE: begin
        if (owner == LABEL_FREE && fits) begin
          res.done     = 1'b1;
          res.grant    = 1'b1;
          res.wr_owner = 1'b1;
          res.owner    = user;
          res.offset   = fill[OFFSET_W-1:0];
        end
      end
      ACT_COMMIT: begin
        if (owner == user) begin
          res.done = 1'b1;
          if (fits) begin
            res.wr_fill = 1'b1;
            res.fill    = sum[FILL_W-1:0];
          end else begin
            res.status = ST_OVERFLOW;
          end
        end
      end
      ACT_RELEASE: begin
        if (owner == user) begin
          res.done     = 1'b1;
          res.wr_owner = 1'b1;
          res.owner    = LABEL_FREE;
        end
      end
      ACT_SERVICE: begin
        if (owner == LABEL_DMA) begin
          res.wr_owner = 1'b1;
          res.owner    = LABEL_FREE;
        end else if (owner == LABEL_FREE && fill != '0) begin
          res.done     = 1'b1;
          res.grant    = 1'b1;
          res.wr_owner = 1'b1;
          res.owner    = LABEL_DMA;
          res.wr_fill  = 1'b1;
          res.fill     = '0;
          res.length   = LENGTH_W'(fill);
          res.start    = 1'b1;
        end
      end
      default: res = '0;
    endcase
  end

endmodule

// ----- bench/pool_scoreboard_pkg.sv -----
// scoreboard class holding a cycle-free model of the transmit buffer pool
package pool_scoreboard_pkg;
  import bpm_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [IDX_W-1:0]    index;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic                start;
  } pool_result_t;

  class pool_scoreboard;
    logic [LABEL_W-1:0] owner [NUM_BUFFERS];
    logic [FILL_W-1:0]  fill  [NUM_BUFFERS];
    logic [LABEL_W-1:0] label_low;
    logic [LABEL_W-1:0] label_high;
    pool_result_t       expected_q [$];
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        status_count [8];

    function new();
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        owner[i] = LABEL_FREE;
        fill[i]  = '0;
      end
      label_low    = LABEL_LOW_RST;
      label_high   = LABEL_HIGH_RST;
      mismatches   = 0;
      results_seen = 0;
      foreach (status_count[s]) status_count[s] = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [LABEL_W-1:0] data);
      if (index == REG_LABEL_LOW) label_low = data;
      else if (index == REG_LABEL_HIGH) label_high = data;
    endfunction

    function bit label_ok(logic [LABEL_W-1:0] user);
      return user != LABEL_FREE && user != LABEL_DMA && user >= label_low && user <= label_high;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // work out the result of one accepted request and update the pool
    function void note_request(action_t act, logic [LABEL_W-1:0] user,
                               logic [SIZE_W-1:0] size, logic busy);
      pool_result_t r;
      bit           found;
      int           i;
      int           sum;
      r        = '0;
      r.status = ST_OK;
      found    = 1'b0;
      if (act == ACT_SERVICE) begin
        if (busy) begin
          r.status = ST_BUSY;
        end else begin
          for (i = 0; i < NUM_BUFFERS && !found; i++) begin
            // a buffer back from the dma is freed but not sent again on this walk
            if (owner[i] == LABEL_DMA) begin
              owner[i] = LABEL_FREE;
            end else if (owner[i] == LABEL_FREE && fill[i] != '0) begin
              found    = 1'b1;
              owner[i] = LABEL_DMA;
              r.index  = IDX_W'(i);
              r.length = LENGTH_W'(fill[i]);
              r.start  = 1'b1;
              fill[i]  = '0;
            end
          end
          if (!found) r.status = ST_NO_DATA;
        end
      end else if (!label_ok(user)) begin
        r.status = ST_NOT_EXIST;
      end else if (act == ACT_ACQUIRE) begin
        for (i = 0; i < NUM_BUFFERS && !found; i++) begin
          if (owner[i] == LABEL_FREE && BUFFER_BYTES > int'(fill[i]) &&
              BUFFER_BYTES - int'(fill[i]) > int'(size)) begin
            found    = 1'b1;
            owner[i] = user;
            r.index  = IDX_W'(i);
            r.offset = OFFSET_W'(fill[i]);
          end
        end
        if (!found) r.status = ST_ALL_BUSY;
      end else if (act == ACT_COMMIT) begin
        if (int'(size) > BUFFER_BYTES) begin
          r.status = ST_TOO_BIG;
        end else begin
          for (i = 0; i < NUM_BUFFERS && !found; i++) begin
            if (owner[i] == user) begin
              found = 1'b1;
              sum   = int'(fill[i]) + int'(size);
              if (sum >= BUFFER_BYTES) r.status = ST_OVERFLOW;
              else fill[i] = FILL_W'(sum);
            end
          end
          if (!found) r.status = ST_NOT_EXIST;
        end
      end else begin
        for (i = 0; i < NUM_BUFFERS && !found; i++) begin
          if (owner[i] == user) begin
            found    = 1'b1;
            owner[i] = LABEL_FREE;
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void field_check(string name, realtime stamp, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0.1f ns: %s expected %0d actual %0d", stamp, name, want, got);
      end
    endfunction

    function void check_result(pool_result_t got, realtime stamp);
      pool_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0.1f ns: result with nothing outstanding, expected none actual status %0d",
                 stamp, got.status);
        return;
      end
      want = expected_q.pop_front();
      status_count[got.status]++;
      field_check("status", stamp, 8'(want.status), 8'(got.status));
      field_check("buffer_index", stamp, 8'(want.index), 8'(got.index));
      field_check("write_offset", stamp, 8'(want.offset), 8'(got.offset));
      field_check("transfer_length", stamp, want.length, got.length);
      field_check("start_transfer", stamp, 8'(want.start), 8'(got.start));
    endfunction
  endclass

endpackage

// ----- bench/tb_tx_buffer_pool_manager.sv -----
// top-level testbench of the transmit buffer pool manager
module tb_tx_buffer_pool_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import bpm_pkg::*;
  import pool_scoreboard_pkg::*;

  // generous: covers every transaction plus gaps and stalls
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int          PHASE_ITEMS = 250;
  localparam int          PHASES      = 6;

  // register indexes past the label window, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_action;
  logic [LABEL_W-1:0]    in_user;
  logic [SIZE_W-1:0]     in_size;
  logic                  in_channel_busy;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [IDX_W-1:0]      out_buffer_index;
  logic [OFFSET_W-1:0]   out_write_offset;
  logic [LENGTH_W-1:0]   out_transfer_length;
  logic                  out_start_transfer;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [LABEL_W-1:0]    cfg_data;

  pool_scoreboard        sb = new();

  // label window as the stimulus sees it, used to aim users at valid labels
  logic [LABEL_W-1:0]    win_low  = LABEL_LOW_RST;
  logic [LABEL_W-1:0]    win_high = LABEL_HIGH_RST;
  bit                    quiet = 1'b0;   // no idling on either side while set
  int unsigned           cycles = 0;
  int unsigned           requests = 0;
  int unsigned           windows = 0;

  always #4 clk = ~clk;

  tx_buffer_pool_manager uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_user             (in_user),
    .in_size             (in_size),
    .in_channel_busy     (in_channel_busy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_buffer_index    (out_buffer_index),
    .out_write_offset    (out_write_offset),
    .out_transfer_length (out_transfer_length),
    .out_start_transfer  (out_start_transfer),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("tb_tx_buffer_pool_manager: errors");
      $finish;
    end
  end

  // result monitor: a transaction completes on valid with no stall at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(pool_result_t'{status: status_t'(out_status), index: out_buffer_index,
                                     offset: out_write_offset, length: out_transfer_length,
                                     start: out_start_transfer}, $realtime);
    end
  end

  // receiver back-pressure, raised at random with a six percent chance outside the quiet stretch
  always @(negedge clk) begin
    out_stall <= rst_n && !quiet && ($urandom_range(0, 99) < 6);
  end

  // present one request and hold it until it is taken; valid stays high for a
  // following request unless an idle gap is drawn
  task automatic send_request(input action_t act, input logic [LABEL_W-1:0] user,
                              input logic [SIZE_W-1:0] size, input logic busy);
    in_valid        <= 1'b1;
    in_action       <= act;
    in_user         <= user;
    in_size         <= size;
    in_channel_busy <= busy;
    do @(posedge clk); while (in_stall);
    sb.note_request(act, user, size, busy);
    requests++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_pool();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // one register write transaction; the caller lowers cfg_valid after a batch
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [LABEL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(index, data);
    @(negedge clk);
  endtask

  // only ever called with the pool drained, so the block is idle
  task automatic set_window(input logic [LABEL_W-1:0] low, input logic [LABEL_W-1:0] high);
    write_register(REG_LABEL_LOW, low);
    write_register(REG_LABEL_HIGH, high);
    cfg_valid <= 1'b0;
    win_low  = low;
    win_high = high;
    windows++;
  endtask

  // random request, biased towards sequences that a real user issues:
  // commits and releases mostly come from whoever holds a buffer
  task automatic random_request();
    action_t             act;
    logic [LABEL_W-1:0]  user;
    logic [SIZE_W-1:0]   size;
    logic                busy;
    int                  roll;
    int                  lo;
    int                  pick;
    roll = $urandom_range(0, 99);
    if (roll < 25) act = ACT_ACQUIRE;
    else if (roll < 55) act = ACT_COMMIT;
    else if (roll < 70) act = ACT_RELEASE;
    else act = ACT_SERVICE;
    lo = (win_low < 2) ? 2 : int'(win_low);
    if ($urandom_range(0, 9) == 0 || lo > int'(win_high)) user = LABEL_W'($urandom_range(0, 15));
    else user = LABEL_W'($urandom_range(lo, win_high));
    if ((act == ACT_COMMIT || act == ACT_RELEASE) && $urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, NUM_BUFFERS - 1);
      if (sb.owner[pick] > LABEL_DMA) user = sb.owner[pick];
    end
    if (act == ACT_COMMIT && $urandom_range(0, 9) < 7) size = SIZE_W'($urandom_range(0, 50));
    else if (act == ACT_ACQUIRE && $urandom_range(0, 9) < 8)
      size = SIZE_W'($urandom_range(0, 127));
    else size = SIZE_W'($urandom_range(0, 255));
    if (act == ACT_SERVICE) busy = ($urandom_range(0, 3) == 0);
    else busy = 1'($urandom_range(0, 1));
    send_request(act, user, size, busy);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_ACQUIRE;
    in_user         = '0;
    in_size         = '0;
    in_channel_busy = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_LABEL_LOW;
    cfg_data        = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty pool, then the buffers pushed through every outcome
    send_request(ACT_SERVICE, 4'd0, 8'd0, 1'b0);        // nothing to send
    send_request(ACT_SERVICE, 4'd15, 8'hff, 1'b1);      // channel busy
    send_request(ACT_ACQUIRE, LABEL_FREE, 8'd0, 1'b0);  // reserved label
    send_request(ACT_COMMIT, LABEL_DMA, 8'd1, 1'b0);    // reserved label
    send_request(ACT_ACQUIRE, 4'd2, 8'd0, 1'b0);        // buffer 0, offset 0
    send_request(ACT_COMMIT, 4'd2, 8'd255, 1'b0);       // too big
    send_request(ACT_COMMIT, 4'd2, 8'd128, 1'b0);       // exactly full counts as overflow
    send_request(ACT_COMMIT, 4'd2, 8'd127, 1'b0);       // largest fill
    send_request(ACT_COMMIT, 4'd2, 8'd1, 1'b0);         // one byte too many
    send_request(ACT_COMMIT, 4'd9, 8'd5, 1'b0);         // commit with no buffer held
    send_request(ACT_RELEASE, 4'd2, 8'd0, 1'b0);
    send_request(ACT_ACQUIRE, 4'd15, 8'd0, 1'b0);       // one byte left, offset 127
    send_request(ACT_ACQUIRE, 4'd3, 8'd127, 1'b0);      // buffer 1
    send_request(ACT_ACQUIRE, 4'd4, 8'd255, 1'b1);      // nothing has room
    send_request(ACT_ACQUIRE, 4'd4, 8'd5, 1'b0);        // buffer 2
    send_request(ACT_ACQUIRE, 4'd5, 8'd0, 1'b0);        // pool exhausted
    send_request(ACT_RELEASE, 4'd7, 8'd0, 1'b0);        // releasing nothing is fine
    send_request(ACT_COMMIT, 4'd3, 8'd40, 1'b0);
    send_request(ACT_COMMIT, 4'd4, 8'd0, 1'b0);         // zero-length commit
    send_request(ACT_RELEASE, 4'd15, 8'd0, 1'b0);
    send_request(ACT_RELEASE, 4'd3, 8'd0, 1'b0);
    send_request(ACT_RELEASE, 4'd4, 8'd0, 1'b0);
    send_request(ACT_SERVICE, 4'd0, 8'd0, 1'b0);        // hands over buffer 0
    send_request(ACT_SERVICE, 4'd0, 8'd0, 1'b0);        // frees buffer 0, hands over buffer 1
    send_request(ACT_SERVICE, 4'd0, 8'd0, 1'b0);        // frees buffer 1, nothing left

    // label window extremes, each written with the pool drained
    drain_pool();
    set_window(4'd15, 4'd15);
    send_request(ACT_ACQUIRE, 4'd15, 8'd0, 1'b0);
    send_request(ACT_ACQUIRE, 4'd14, 8'd0, 1'b0);
    drain_pool();
    set_window(4'd15, 4'd2);                            // inverted window, no label valid
    send_request(ACT_RELEASE, 4'd15, 8'd0, 1'b0);
    drain_pool();
    set_window(4'd0, 4'd15);                            // low bound below the reserved labels
    send_request(ACT_ACQUIRE, LABEL_FREE, 8'd0, 1'b0);
    send_request(ACT_RELEASE, 4'd15, 8'd0, 1'b0);

    // random phases; each boundary is a pause until every result is back
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pool();
      quiet = (phase == 3);
      case (phase)
        0: set_window(LABEL_LOW_RST, LABEL_HIGH_RST);
        1: set_window(4'd2, 4'd5);
        2: set_window(4'd12, 4'd15);
        3: set_window(LABEL_LOW_RST, LABEL_HIGH_RST);
        4: begin
          // unknown indexes must leave the window alone
          write_register(REG_SPARE_A, LABEL_W'($urandom_range(0, 15)));
          write_register(REG_SPARE_B, LABEL_W'($urandom_range(0, 15)));
          set_window(LABEL_W'($urandom_range(0, 6)), LABEL_W'($urandom_range(8, 15)));
        end
        default: set_window(LABEL_W'($urandom_range(0, 15)), LABEL_W'($urandom_range(0, 15)));
      endcase
      repeat (PHASE_ITEMS) random_request();
    end
    quiet = 1'b0;

    drain_pool();
    repeat (8) @(negedge clk);
    $display("covered %0d requests and %0d results across %0d label windows",
             requests, sb.results_seen, windows);
    $display("outcomes: ok %0d, busy %0d, no data %0d, all busy %0d, too big %0d, %s %0d, %s %0d",
             sb.status_count[ST_OK], sb.status_count[ST_BUSY], sb.status_count[ST_NO_DATA],
             sb.status_count[ST_ALL_BUSY], sb.status_count[ST_TOO_BIG],
             "overflow", sb.status_count[ST_OVERFLOW], "not exist", sb.status_count[ST_NOT_EXIST]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_tx_buffer_pool_manager: clean");
    end else begin
      $display("tb_tx_buffer_pool_manager: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bpm_pkg.sv
hdl/bpm_step_unit.sv
hdl/tx_buffer_pool_manager.sv
bench/pool_scoreboard_pkg.sv
bench/tb_tx_buffer_pool_manager.sv
